>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Needs no other file; every macro takes a label, clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/ilst_pkg.sv
// Types and constants of the IDE LBA sector transfer block.
// Used by the front, back, top level and checker; depends on nothing.
package ilst_pkg;

  localparam int NUM_REGS    = 8;
  localparam int IDX_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int LBA_W       = 28;
  localparam int OFFSET_W    = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Task register indexes
  localparam logic [IDX_W-1:0] REG_DATA   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SECCNT = 3'd2;
  localparam logic [IDX_W-1:0] REG_LBA0   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LBA1   = 3'd4;
  localparam logic [IDX_W-1:0] REG_LBA2   = 3'd5;
  localparam logic [IDX_W-1:0] REG_LBA3   = 3'd6;
  localparam logic [IDX_W-1:0] REG_STATUS = 3'd7;

  // Command and status codes
  localparam logic [BYTE_W-1:0] CMD_TRANSFER       = 8'h08;
  localparam logic [BYTE_W-1:0] STATUS_IDLE        = 8'h00;
  localparam logic [BYTE_W-1:0] STATUS_WRITE_FAULT = 8'h34;
  localparam logic [BYTE_W-1:0] STATUS_READ_FAULT  = 8'h24;
  localparam logic [3:0]        LBA_TOP_MASK       = 4'hF;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // One classified bus access waiting in the queue
  typedef struct packed {
    op_e               opcode;
    logic [IDX_W-1:0]  reg_index;
    logic [BYTE_W-1:0] write_data;
    logic              is_data;
  } item_t;

endpackage

>>> rtl/ilst_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; no package needed.
module ilst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ilst_front.sv
// Front end: takes bus accesses, classifies them and queues them for the back end.
// Depends on ilst_pkg.
module ilst_front import ilst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hold_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [IDX_W-1:0]  reg_index_i,
  input  logic [BYTE_W-1:0] write_data_i,
  output logic              q_valid_o,
  output item_t             q_item_o,
  input  logic              q_pop_i
);

  item_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               push;
  logic               pop;
  item_t              new_item;

  assign in_stall_o = (cnt_q == QCNT_W'(QUEUE_DEPTH)) || hold_i;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    new_item.opcode     = op_e'(opcode_i);
    new_item.reg_index  = reg_index_i;
    new_item.write_data = write_data_i;
    new_item.is_data    = (reg_index_i == REG_DATA);
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/ilst_back.sv
// Back end: task registers, transfer offset, byte store and result register.
// Depends on ilst_pkg and ilst_ram.
module ilst_back import ilst_pkg::*; #(
  parameter int SECTOR_BYTES = 512,
  parameter int STORE_BYTES  = 1048576
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              q_pop_o,
  output logic              clearing_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] read_data_o,
  output logic [BYTE_W-1:0] status_o,
  output logic              save_request_o
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int SW = $clog2(SECTOR_BYTES + 1);
  localparam int BW = LBA_W + SW;
  localparam int TW = BYTE_W + SW;
  localparam int NW = OFFSET_W + 1;
  localparam int CW = (TW > NW) ? TW : NW;

  logic [BYTE_W-1:0]   regs_q [NUM_REGS];
  logic [BYTE_W-1:0]   regs_d [NUM_REGS];
  logic                pend_q, pend_d;
  logic [BW-1:0]       base_q, base_d;
  logic [TW-1:0]       total_q, total_d;
  logic [OFFSET_W-1:0] off_q, off_d;
  logic [AW-1:0]       offmod_q, offmod_d;
  logic                clear_busy_q;
  logic [AW-1:0]       clear_addr_q;

  logic                out_valid_q;
  logic                out_sel_q;
  logic [BYTE_W-1:0]   out_data_q;
  logic [BYTE_W-1:0]   out_status_q;
  logic                out_save_q;

  logic                fire;
  logic                is_write;
  logic                xfer;
  logic                oor;
  logic                move;
  logic                done;
  logic [AW:0]         addr_sum;
  logic [AW-1:0]       addr;
  logic [NW-1:0]       next_off;
  logic [AW:0]         offmod_inc;
  logic [AW-1:0]       offmod_next;
  logic [BYTE_W-1:0]   reg0_eff;
  logic [LBA_W-1:0]    lba_d;
  logic                save;

  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       ram_addr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [BYTE_W-1:0]   ram_rdata;

  ilst_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign clearing_o = clear_busy_q;
  assign fire       = q_valid_i && !clear_busy_q && (!out_valid_q || !out_stall_i);
  assign q_pop_o    = fire;

  // Data register still waiting on the store read of the previous transfer
  assign reg0_eff = pend_q ? ram_rdata : regs_q[REG_DATA];

  assign is_write = (q_item_i.opcode == OP_WRITE);
  assign xfer     = q_item_i.is_data && (regs_q[REG_STATUS] == CMD_TRANSFER);
  assign oor      = (base_q >= BW'(STORE_BYTES));
  assign move     = fire && xfer && !oor;

  // Offset is kept reduced modulo the store size, so one subtract wraps the sum
  assign addr_sum = (AW+1)'(base_q[AW-1:0]) + (AW+1)'(offmod_q);
  assign addr     = (addr_sum >= (AW+1)'(STORE_BYTES))
                    ? AW'(addr_sum - (AW+1)'(STORE_BYTES)) : addr_sum[AW-1:0];

  assign next_off    = NW'(off_q) + NW'(1);
  assign done        = (CW'(next_off) >= CW'(total_q));
  assign offmod_inc  = (AW+1)'(offmod_q) + (AW+1)'(1);
  assign offmod_next = (next_off[OFFSET_W] || (offmod_inc == (AW+1)'(STORE_BYTES)))
                       ? '0 : offmod_inc[AW-1:0];

  always_comb begin
    regs_d           = regs_q;
    regs_d[REG_DATA] = reg0_eff;
    off_d            = off_q;
    offmod_d         = offmod_q;
    pend_d           = 1'b0;
    save             = 1'b0;
    if (fire) begin
      if (is_write) begin
        regs_d[q_item_i.reg_index] = q_item_i.write_data;
      end
      if (xfer && oor) begin
        regs_d[REG_STATUS] = is_write ? STATUS_WRITE_FAULT : STATUS_READ_FAULT;
        off_d              = '0;
        offmod_d           = '0;
      end else if (xfer) begin
        pend_d = !is_write;
        if (done) begin
          regs_d[REG_STATUS] = STATUS_IDLE;
          off_d              = '0;
          offmod_d           = '0;
          save               = is_write;
        end else begin
          off_d    = next_off[OFFSET_W-1:0];
          offmod_d = offmod_next;
        end
      end
    end
  end

  assign lba_d   = {regs_d[REG_LBA3][3:0] & LBA_TOP_MASK, regs_d[REG_LBA2],
                    regs_d[REG_LBA1], regs_d[REG_LBA0]};
  assign base_d  = BW'(lba_d) * BW'(SECTOR_BYTES);
  assign total_d = TW'(regs_d[REG_SECCNT]) * TW'(SECTOR_BYTES);

  // Store port: clearing sweep after reset, then one byte per transfer
  always_comb begin
    if (clear_busy_q) begin
      ram_we    = 1'b1;
      ram_re    = 1'b0;
      ram_addr  = clear_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = move && is_write;
      ram_re    = move && !is_write;
      ram_addr  = addr;
      ram_wdata = q_item_i.write_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
      pend_q       <= 1'b0;
      base_q       <= '0;
      total_q      <= '0;
      off_q        <= '0;
      offmod_q     <= '0;
      clear_busy_q <= 1'b1;
      clear_addr_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      regs_q   <= regs_d;
      pend_q   <= pend_d;
      base_q   <= base_d;
      total_q  <= total_d;
      off_q    <= off_d;
      offmod_q <= offmod_d;
      if (clear_busy_q) begin
        clear_addr_q <= clear_addr_q + 1'b1;
        if (clear_addr_q == AW'(STORE_BYTES - 1)) begin
          clear_busy_q <= 1'b0;
        end
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; a read transfer takes its byte straight from the store
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_sel_q    <= pend_d;
      out_data_q   <= regs_d[q_item_i.reg_index];
      out_status_q <= regs_d[REG_STATUS];
      out_save_q   <= save;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_sel_q ? ram_rdata : out_data_q;
  assign status_o       = out_status_q;
  assign save_request_o = out_save_q;

endmodule

>>> rtl/ide_lba_sector_transfer_top.sv
// IDE task-file device with LBA28 programmed-I/O sector transfer. Each bus access
// gives one registered result; the block sustains one access per cycle unless
// out_stall_i or the store sweep holds it: a two-entry queue separates intake
// from execution, and the byte store is a single-port memory with registered read
// that serves one data byte per cycle. After reset the store is swept to zero, one
// byte per cycle, over STORE_BYTES bytes (1048576 by default), with in_stall_o high.
// Depends on ilst_pkg, ilst_front, ilst_back and ilst_ram.
module ide_lba_sector_transfer_top import ilst_pkg::*; #(
  parameter int SECTOR_BYTES = 512,
  parameter int STORE_BYTES  = 1048576
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [IDX_W-1:0]  reg_index_i,
  input  logic [BYTE_W-1:0] write_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] read_data_o,
  output logic [BYTE_W-1:0] status_o,
  output logic              save_request_o
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  logic  clearing;

  ilst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_i       (clearing),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  ilst_back #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .STORE_BYTES  (STORE_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .status_o       (status_o),
    .save_request_o (save_request_o)
  );

endmodule

>>> rtl/ilst_checker.sv
// Port-level checks for the IDE LBA sector transfer top level, bound in below.
// Depends on ilst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ilst_checker import ilst_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [BYTE_W-1:0] read_data_o,
  input logic [BYTE_W-1:0] status_o,
  input logic              save_request_o
);

  // A stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its payload
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
    $stable(read_data_o) && $stable(status_o) && $stable(save_request_o))

  // A completed write transfer always leaves the device idle
  `ASSERT_IMPLIES(a_save_idle, clk_i, rst_ni, out_valid_o && save_request_o,
    status_o == STATUS_IDLE)

  // Store clearing holds off intake straight after reset
  `ASSERT_IMPLIES(a_clear_stall, clk_i, rst_ni, $past(!rst_ni), in_stall_o)

endmodule

bind ide_lba_sector_transfer_top ilst_checker u_ilst_checker (.*);
